// ===== sv/bds_pkg.sv =====
// Shared types and constants for the baud divisor search unit.
// No dependencies; imported by bds_divider, baud_divisor_search_unit and the testbench.
package bds_pkg;

  localparam int unsigned CLK_W     = 28;  // source clock field
  localparam int unsigned BAUD_W    = 24;  // requested baud field
  localparam int unsigned RATIO_OW  = 6;   // ratio output field
  localparam int unsigned DIV_OW    = 27;  // divisor output field
  localparam int unsigned ARITH_W   = 32;  // modular arithmetic width
  localparam int unsigned DQ_W      = CLK_W + 1;  // divisor incl. the +1 case
  localparam int unsigned DIV_CNT_W = $clog2(CLK_W);

  localparam int unsigned BDS_MIN_RATIO = 4;
  localparam int unsigned BDS_MAX_RATIO = 32;

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(80000000);

  localparam int unsigned TOL_DIVISOR   = 100;
  localparam int unsigned TOL_FACTOR    = 3;
  localparam int unsigned BOTH_EDGE_LO  = 3;  // ratio above this
  localparam int unsigned BOTH_EDGE_HI  = 8;  // and below this

  // baud / 100 as (baud * TOL_RECIP) >> TOL_SHIFT, exact for any 24-bit baud
  localparam int unsigned TOL_SHIFT   = 31;
  localparam int unsigned TOL_RECIP_W = 25;
  localparam int unsigned TOL_PROD_W  = BAUD_W + TOL_RECIP_W;
  localparam logic [TOL_RECIP_W-1:0] TOL_RECIP = TOL_RECIP_W'(21474837);  // ceil(2^31 / 100)

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CLK_W-1:0] quotient;
  } div_stat_t;

endpackage

// ===== sv/baud_divisor_search_unit.sv =====
// Top level of the baud divisor search unit: sequencer, trial datapath
// and the shared bds_divider. Uses bds_pkg.
//
// Usage:
//   Write the source clock frequency through cfg_we_i/source_clock_hz_i
//   while the unit is idle; it resets to 80 MHz.
//   Present a baud rate on baud_rate_i and pulse start; the item is taken
//   when start is high and busy is low. busy stays high until the result.
//   The result appears on the output ports for exactly one cycle, marked
//   by done_o; the receiver cannot stall it, so it must capture it then.
// Timing:
//   Every ratio trial runs three divisions on the single shared divider,
//   each made of a launch, the quotient-bit iterations and a hand-back,
//   followed by a compare against the best trial so far.
//   The tolerance bound comes from a reciprocal multiply, not the divider.
//   A zero baud rate skips the search and goes straight to the result.
//   One item at a time: the next item can be taken the cycle after the result.
// Reset: asynchronous, clears the sequencer and restores the clock value.
module baud_divisor_search_unit import bds_pkg::*; #(
  parameter int unsigned MIN_RATIO = BDS_MIN_RATIO,
  parameter int unsigned MAX_RATIO = BDS_MAX_RATIO
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CLK_W-1:0]    source_clock_hz_i,
  input  logic                start,
  output logic                busy,
  input  logic [BAUD_W-1:0]   baud_rate_i,
  output logic                done_o,
  output logic [RATIO_OW-1:0] oversample_ratio_o,
  output logic [DIV_OW-1:0]   baud_divisor_o,
  output logic [BAUD_W-1:0]   baud_error_o,
  output logic                both_edge_sampling_o,
  output logic                within_tolerance_o
);

  localparam int unsigned RW = $clog2(MAX_RATIO + 1);
  localparam logic [RW-1:0] R_MIN = RW'(MIN_RATIO);
  localparam logic [RW-1:0] R_MAX = RW'(MAX_RATIO);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_NEXT = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    PH_DIV0 = 3'b001,  // clk / (baud * r)
    PH_ERR  = 3'b010,  // clk / (r * div)
    PH_ALT  = 3'b100   // clk / (r * (div + 1))
  } phase_e;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic [RW-1:0]    ratio_q, ratio_d;
  logic [CLK_W-1:0] clk_hz_q;

  logic [BAUD_W-1:0]  baud_q;
  logic [DQ_W-1:0]    div_q;
  logic [ARITH_W-1:0] err_q, alt_q, tol_q;
  logic [BAUD_W-1:0]  best_err_q;
  logic [RW-1:0]      best_ratio_q;
  logic [DQ_W-1:0]    best_div_q;

  logic                 accept;
  logic                 div_start;
  logic [CLK_W-1:0]     div_dividend;
  logic [ARITH_W-1:0]   div_divisor;
  div_stat_t            div_stat;
  logic [DQ_W-1:0]      mul_a;
  logic [DQ_W+RW-1:0]   mul_full;
  logic                 use_alt, take;
  logic [ARITH_W-1:0]   cur_err;
  logic [DQ_W-1:0]      cur_div;
  logic [ARITH_W-1:0]   ratio_ext;
  logic [TOL_PROD_W-1:0] tol_prod;
  logic [ARITH_W-1:0]   tol_next;

  assign accept = start && !busy;

  // ---- shared multiplier feeding the divider's divisor register ----
  always_comb begin
    case (ph_q)
      PH_DIV0: mul_a = DQ_W'(baud_q);
      PH_ERR:  mul_a = div_q;
      default: mul_a = div_q + 1'b1;
    endcase
    mul_full     = mul_a * ratio_q;
    div_divisor  = mul_full[ARITH_W-1:0];
    div_dividend = clk_hz_q;
    div_start    = (state_q == ST_MUL);
  end

  // ---- tolerance bound: (baud / 100) * 3 ----
  always_comb begin
    tol_prod = TOL_PROD_W'(baud_q) * TOL_PROD_W'(TOL_RECIP);
    tol_next = ARITH_W'(tol_prod[TOL_PROD_W-1:TOL_SHIFT]) * ARITH_W'(TOL_FACTOR);
  end

  bds_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat)
  );

  // ---- trial selection: divisor or divisor+1, then against the best ----
  always_comb begin
    use_alt = err_q > alt_q;
    cur_err = use_alt ? alt_q : err_q;
    cur_div = use_alt ? div_q + 1'b1 : div_q;
    take    = cur_err <= ARITH_W'(best_err_q);
  end

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    ratio_d = ratio_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ratio_d = R_MIN;
          ph_d    = PH_DIV0;
          state_d = (baud_rate_i == '0) ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_stat.done) begin
          unique case (ph_q)
            PH_DIV0: begin
              ph_d    = PH_ERR;
              state_d = ST_MUL;
            end
            PH_ERR: begin
              ph_d    = PH_ALT;
              state_d = ST_MUL;
            end
            PH_ALT:  state_d = ST_NEXT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_NEXT: begin
        if (ratio_q == R_MAX) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MUL;
          ph_d    = PH_DIV0;
          ratio_d = ratio_q + 1'b1;
        end
      end
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ph_q     <= PH_DIV0;
      ratio_q  <= '0;
      clk_hz_q <= CLK_RESET;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      ratio_q <= ratio_d;
      if (cfg_we_i) begin
        clk_hz_q <= source_clock_hz_i;
      end
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      baud_q       <= baud_rate_i;
      best_err_q   <= baud_rate_i;
      best_ratio_q <= '0;
      best_div_q   <= '0;
      tol_q        <= '0;
    end
    // baud_q is stable from the first launch on
    if (state_q == ST_MUL) begin
      tol_q <= tol_next;
    end
    if (state_q == ST_WAIT && div_stat.done) begin
      case (ph_q)
        PH_DIV0: div_q <= (div_stat.quotient == '0) ? DQ_W'(1) : DQ_W'(div_stat.quotient);
        PH_ERR:  err_q <= ARITH_W'(div_stat.quotient) - ARITH_W'(baud_q);
        default: alt_q <= ARITH_W'(baud_q) - ARITH_W'(div_stat.quotient);
      endcase
    end
    if (state_q == ST_NEXT && take) begin
      // best error never exceeds the baud rate, so 24 bits hold it
      best_err_q   <= cur_err[BAUD_W-1:0];
      best_ratio_q <= ratio_q;
      best_div_q   <= cur_div;
    end
  end

  // ---- outputs ----
  assign busy      = (state_q != ST_IDLE);
  assign done_o    = (state_q == ST_OUT);
  assign ratio_ext = ARITH_W'(best_ratio_q);

  assign oversample_ratio_o   = ratio_ext[RATIO_OW-1:0];
  assign baud_divisor_o       = best_div_q[DIV_OW-1:0];
  assign baud_error_o         = best_err_q;
  assign both_edge_sampling_o = (ratio_ext > ARITH_W'(BOTH_EDGE_LO)) &&
                                (ratio_ext < ARITH_W'(BOTH_EDGE_HI));
  assign within_tolerance_o   = ARITH_W'(best_err_q) < tol_q;

  // ---- assertions ----
  a_start_idle_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider launched while busy");

  a_done_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_WAIT))
    else $error("divider result arrived outside the wait state");

  a_ratio_div_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((best_ratio_q == '0) == (best_div_q == '0)))
    else $error("ratio and divisor disagree on whether a trial was taken");

  a_err_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (best_err_q <= baud_q))
    else $error("best error above requested baud");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after taking an item");

endmodule

// ===== sv/bds_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Divides a CLK_W-bit dividend by an ARITH_W-bit divisor; uses bds_pkg.
module bds_divider import bds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CLK_W-1:0]   dividend_i,
  input  logic [ARITH_W-1:0] divisor_i,
  output div_stat_t          stat_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ARITH_W-1:0]   rem_q, rem_d;
  logic [CLK_W-1:0]     dvd_q, dvd_d;
  logic [ARITH_W-1:0]   dvs_q;
  logic [ARITH_W:0]     partial, diff;
  logic                 fits;

  always_comb begin
    partial = {rem_q, dvd_q[CLK_W-1]};
    diff    = partial - {1'b0, dvs_q};
    fits    = ~diff[ARITH_W];
    // remainder stays below the divisor, so dropping the top bit is safe
    rem_d   = fits ? diff[ARITH_W-1:0] : partial[ARITH_W-1:0];
    dvd_d   = {dvd_q[CLK_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(CLK_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.done     = done_q;
  assign stat_o.quotient = dvd_q;

endmodule

// ===== sim/tb_baud_divisor_search_unit.sv =====
// Self-checking testbench for baud_divisor_search_unit: directed and random baud
// rates under several source clock settings, results checked against a predictor.
// Depends on bds_pkg and baud_divisor_search_unit.
module tb_baud_divisor_search_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bds_pkg::*;

  typedef struct packed {
    logic [RATIO_OW-1:0] ratio;
    logic [DIV_OW-1:0]   divisor;
    logic [BAUD_W-1:0]   err;
    logic                both_edge;
    logic                in_tol;
  } baud_fit_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CLK_W-1:0]    source_clock_hz_i = '0;
  logic                start = 1'b0;
  logic                busy;
  logic [BAUD_W-1:0]   baud_rate_i = '0;
  logic                done_o;
  logic [RATIO_OW-1:0] oversample_ratio_o;
  logic [DIV_OW-1:0]   baud_divisor_o;
  logic [BAUD_W-1:0]   baud_error_o;
  logic                both_edge_sampling_o;
  logic                within_tolerance_o;

  logic [BAUD_W-1:0] pending_bauds[$];
  baud_fit_t         expected_fits[$];
  logic [CLK_W-1:0]  model_src_clk = CLK_RESET;
  logic              item_taken = 1'b0;
  int unsigned       idle_gap = 0;
  int unsigned       burst_left = 1;
  int unsigned       errors = 0;
  int unsigned       std_rates[6] = '{9600, 19200, 57600, 115200, 460800, 1000000};

  baud_divisor_search_unit u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .source_clock_hz_i   (source_clock_hz_i),
    .start               (start),
    .busy                (busy),
    .baud_rate_i         (baud_rate_i),
    .done_o              (done_o),
    .oversample_ratio_o  (oversample_ratio_o),
    .baud_divisor_o      (baud_divisor_o),
    .baud_error_o        (baud_error_o),
    .both_edge_sampling_o(both_edge_sampling_o),
    .within_tolerance_o  (within_tolerance_o)
  );

  // divide by zero gives all ones
  function automatic logic [31:0] quot32(logic [31:0] a, logic [31:0] b);
    return (b == 0) ? 32'hFFFF_FFFF : a / b;
  endfunction

  // Search ratios for the best divisor; all differences wrap at 32 bits.
  function automatic baud_fit_t fit_baud(logic [CLK_W-1:0] clk_hz, logic [BAUD_W-1:0] baud);
    logic [31:0] clk32, b32, dv, err, alt, best_err, best_div, best_ratio;
    baud_fit_t res;
    clk32 = 32'(clk_hz);
    b32 = 32'(baud);
    best_err = b32;
    best_div = '0;
    best_ratio = '0;
    if (b32 != 0) begin
      for (int unsigned r = BDS_MIN_RATIO; r <= BDS_MAX_RATIO; r++) begin
        dv = quot32(clk32, b32 * 32'(r));
        if (dv == 0) dv = 32'd1;
        err = quot32(clk32, 32'(r) * dv) - b32;
        alt = b32 - quot32(clk32, 32'(r) * (dv + 32'd1));
        if (err > alt) begin
          err = alt;
          dv = dv + 32'd1;
        end
        // ties go to the later ratio
        if (err <= best_err) begin
          best_err = err;
          best_div = dv;
          best_ratio = 32'(r);
        end
      end
    end
    res.ratio = best_ratio[RATIO_OW-1:0];
    res.divisor = best_div[DIV_OW-1:0];
    res.err = best_err[BAUD_W-1:0];
    res.both_edge = (best_ratio > BOTH_EDGE_LO) && (best_ratio < BOTH_EDGE_HI);
    res.in_tol = best_err < (b32 / TOL_DIVISOR) * TOL_FACTOR;
    return res;
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Driver: bursts of back-to-back items, random gaps between bursts.
  always @(negedge clk_i) begin
    logic next_start;
    next_start = start && !item_taken;
    if (!next_start) begin
      if (idle_gap != 0) begin
        idle_gap--;
      end else if (pending_bauds.size() != 0) begin
        baud_rate_i <= pending_bauds.pop_front();
        next_start = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 6);
          // long gaps land the next start around the end of the search
          case ($urandom_range(0, 15))
            0:       idle_gap = $urandom_range(2600, 2700);
            1, 2, 3: idle_gap = $urandom_range(10, 60);
            default: idle_gap = $urandom_range(0, 4);
          endcase
        end
      end
    end
    start <= next_start;
  end

  // Monitor: predicts on acceptance, checks each result against the oldest prediction.
  always @(posedge clk_i) begin
    baud_fit_t want, got;
    if (!rst_ni) begin
      item_taken <= 1'b0;
    end else begin
      if (done_o) begin
        got = '{oversample_ratio_o, baud_divisor_o, baud_error_o,
                both_edge_sampling_o, within_tolerance_o};
        if (expected_fits.size() == 0) begin
          $display("%0t ns: result with no item pending: ratio %0d div %0d err %0d",
                   $time, got.ratio, got.divisor, got.err);
          errors++;
        end else begin
          want = expected_fits.pop_front();
          if (got !== want) begin
            $display("%0t ns: mismatch expected ratio %0d div %0d err %0d both %b tol %b",
                     $time, want.ratio, want.divisor, want.err, want.both_edge, want.in_tol);
            $display("%0t ns:          actual ratio %0d div %0d err %0d both %b tol %b",
                     $time, got.ratio, got.divisor, got.err, got.both_edge, got.in_tol);
            errors++;
          end
        end
      end
      if (start && !busy) expected_fits.push_back(fit_baud(model_src_clk, baud_rate_i));
      item_taken <= start && !busy;
    end
  end

  // checked at the rising edge, where start and the queue are settled
  task automatic wait_drained();
    do
      @(posedge clk_i);
    while (pending_bauds.size() != 0 || start || busy || expected_fits.size() != 0);
  endtask

  task automatic program_clock(logic [CLK_W-1:0] hz);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    source_clock_hz_i <= hz;
    model_src_clk = hz;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] near;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset clock value: zero rate, extremes and common rates
    pending_bauds.push_back(24'd0);
    pending_bauds.push_back(24'd1);
    pending_bauds.push_back(24'hFFFFFF);
    pending_bauds.push_back(24'd9600);
    pending_bauds.push_back(24'd115200);
    pending_bauds.push_back(24'd921600);
    pending_bauds.push_back(24'd3000000);
    pending_bauds.push_back(BAUD_W'(32'd20000000));
    pending_bauds.push_back(24'h800000);
    pending_bauds.push_back(24'h555555);
    pending_bauds.push_back(24'hAAAAAA);

    program_clock(28'hFFFFFFF);
    pending_bauds.push_back(24'd1);
    pending_bauds.push_back(24'd115200);
    pending_bauds.push_back(24'd8388607);
    pending_bauds.push_back(24'hFFFFFF);

    // tiny clock: divisors forced to 1, errors wrap
    program_clock(28'd1);
    pending_bauds.push_back(24'd1);
    pending_bauds.push_back(24'hFFFFFF);

    program_clock(28'd0);
    pending_bauds.push_back(24'd1);
    pending_bauds.push_back(24'd7);
    pending_bauds.push_back(24'd0);
    pending_bauds.push_back(24'hFFFFFF);

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 4))
        0:       program_clock(CLK_W'($urandom_range(1, 268435455)));
        1:       program_clock(CLK_W'($urandom_range(1, 1000)));
        2:       program_clock(CLK_W'($urandom_range(8000000, 200000000)));
        3:       program_clock(CLK_RESET);
        default: program_clock(CLK_W'($urandom));
      endcase
      for (int i = 0; i < 25; i++) begin
        case ($urandom_range(0, 5))
          0: pending_bauds.push_back(BAUD_W'($urandom));
          1: pending_bauds.push_back(BAUD_W'($urandom_range(1, 1000)));
          2: pending_bauds.push_back(BAUD_W'($urandom_range(1000, 5000000)));
          3: begin
            // rates close to an exact clock / (ratio * divisor)
            near = 32'(model_src_clk) / ($urandom_range(4, 32) * $urandom_range(1, 8));
            pending_bauds.push_back(BAUD_W'(near + $urandom_range(0, 4)));
          end
          4: pending_bauds.push_back(BAUD_W'(std_rates[$urandom_range(0, 5)]));
          default: pending_bauds.push_back(BAUD_W'($urandom_range(0, 3)));
        endcase
      end
    end

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bds_pkg.sv
sv/bds_divider.sv
sv/baud_divisor_search_unit.sv
sim/tb_baud_divisor_search_unit.sv
